// ----- design/sha512_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-512 package
// Types, round constants and initial hash words shared by the hash engine.
// ----------------------------------------------------------------------------
package sha512_pkg;

   localparam int WordWidth   = 64;
   localparam int RoundCount  = 80;
   localparam int BlockWords  = 16;
   localparam int DigestWords = 8;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [6:0]           round_type;

   // sequencer states of the top level
   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_PAD     = 6'b000010,
      ST_COMP    = 6'b000100,
      ST_FOLD    = 6'b001000,
      ST_EMIT    = 6'b010000,
      ST_LENGTH  = 6'b100000
   } state_type;

   // control from sequencer to round unit
   typedef struct packed {
      logic      load;   // copy chaining value into a..h
      logic      step;   // execute one round
      round_type rnd;    // current round number
   } round_ctl_type;

   function automatic word_type round_const(input round_type r);
      word_type k;
      unique case (r)
         7'd0:  k = 64'h428a2f98d728ae22; 7'd1:  k = 64'h7137449123ef65cd;
         7'd2:  k = 64'hb5c0fbcfec4d3b2f; 7'd3:  k = 64'he9b5dba58189dbbc;
         7'd4:  k = 64'h3956c25bf348b538; 7'd5:  k = 64'h59f111f1b605d019;
         7'd6:  k = 64'h923f82a4af194f9b; 7'd7:  k = 64'hab1c5ed5da6d8118;
         7'd8:  k = 64'hd807aa98a3030242; 7'd9:  k = 64'h12835b0145706fbe;
         7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
         7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
         7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
         7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
         7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
         7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
         7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
         7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
         7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
         7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
         7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
         7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
         7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
         7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
         7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
         7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
         7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
         7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
         7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
         7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
         7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
         7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
         7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
         7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
         7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
         7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
         7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
         7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
         7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
         7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
         7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
         7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
         7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
         7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
         7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
         default: k = '0;
      endcase
      return k;
   endfunction

   function automatic word_type init_word(input logic mode, input logic [2:0] idx);
      word_type w;
      unique case ({mode, idx})
         4'h0: w = 64'h6a09e667f3bcc908; 4'h1: w = 64'hbb67ae8584caa73b;
         4'h2: w = 64'h3c6ef372fe94f82b; 4'h3: w = 64'ha54ff53a5f1d36f1;
         4'h4: w = 64'h510e527fade682d1; 4'h5: w = 64'h9b05688c2b3e6c1f;
         4'h6: w = 64'h1f83d9abfb41bd6b; 4'h7: w = 64'h5be0cd19137e2179;
         4'h8: w = 64'hcbbb9d5dc1059ed8; 4'h9: w = 64'h629a292a367cd507;
         4'ha: w = 64'h9159015a3070dd17; 4'hb: w = 64'h152fecd8f70e5939;
         4'hc: w = 64'h67332667ffc00b31; 4'hd: w = 64'h8eb44a8768581511;
         4'he: w = 64'hdb0c2e0d64f98fa7; 4'hf: w = 64'h47b5481dbefa4fa4;
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic word_type ror64(input word_type x, input int n);
      return (x >> n) | (x << (WordWidth - n));
   endfunction

endpackage

// ----- design/sha512_round.sv -----
// ----------------------------------------------------------------------------
// SHA-512 round unit
// Holds a..h and the 16-word schedule window; one round per step.
// ----------------------------------------------------------------------------
module sha512_round (
   input  logic                       clock,
   input  sha512_pkg::round_ctl_type  ctl,
   input  sha512_pkg::word_type       cv [8],
   input  logic                       wr_en,     // block word write
   input  logic [3:0]                 wr_addr,
   input  sha512_pkg::word_type       wr_data,
   output sha512_pkg::word_type       vars [8]
);
   sha512_pkg::word_type v_ff [8];
   sha512_pkg::word_type v_in [8];
   sha512_pkg::word_type w_ff [16];
   sha512_pkg::word_type w_in [16];

   always_comb begin
      logic [3:0] t;
      sha512_pkg::word_type x, y, s0, s1, wt, e, a, t1, t2;
      t = ctl.rnd[3:0];
      x = w_ff[t + 4'd1];
      y = w_ff[t + 4'd14];
      s0 = sha512_pkg::ror64(x, 1) ^ sha512_pkg::ror64(x, 8) ^ (x >> 7);
      s1 = sha512_pkg::ror64(y, 19) ^ sha512_pkg::ror64(y, 61) ^ (y >> 6);
      wt = (ctl.rnd >= 7'd16) ? w_ff[t] + s0 + w_ff[t + 4'd9] + s1 : w_ff[t];
      e = v_ff[4];
      a = v_ff[0];
      t1 = v_ff[7] + (sha512_pkg::ror64(e, 14) ^ sha512_pkg::ror64(e, 18)
           ^ sha512_pkg::ror64(e, 41)) + ((e & v_ff[5]) ^ (~e & v_ff[6]))
           + sha512_pkg::round_const(ctl.rnd) + wt;
      t2 = (sha512_pkg::ror64(a, 28) ^ sha512_pkg::ror64(a, 34) ^ sha512_pkg::ror64(a, 39))
           + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      v_in = v_ff;
      w_in = w_ff;
      if (ctl.load) begin
         v_in = cv;
      end else if (ctl.step) begin
         v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = e; v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2]; v_in[2] = v_ff[1]; v_in[1] = a; v_in[0] = t1 + t2;
         w_in[t] = wt;
      end
      if (wr_en) begin
         w_in[wr_addr] = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      w_ff <= w_in;
   end

   assign vars = v_ff;
endmodule

// ----- design/sha512_384_hash_engine.sv -----
// ----------------------------------------------------------------------------
// SHA-512 / SHA-384 hash engine
// Streams big-endian 64-bit message words in, streams the digest out.
// ----------------------------------------------------------------------------
// One request transaction carries one message word. A word that does not fill
// a block is stored and the engine stays ready; the word that fills a block
// starts a compression (one round per cycle in a single shared round unit)
// and a fold into the chaining value, during which req_tready is low. A last
// word additionally runs padding (zero words written one by one) and one or
// two compressions, then sends 8 (SHA-512) or 6 (SHA-384) response
// transactions. csr_tdata[0] selects the mode; write it only while the engine
// is idle.
module sha512_384_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [63:0] data_word, [67:64] valid_bytes, zero fill
   input  logic        req_tlast,   // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast,   // last_digest
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [7:0]  csr_tdata    // [0] hash_mode
);
   sha512_pkg::state_type state_ff, state_in;
   logic                  mode_ff, mode_in;
   logic                  open_ff, open_in;
   logic [4:0]            fill_ff, fill_in;       // words in block
   logic [127:0]          len_ff, len_in;         // message bit length
   sha512_pkg::round_type rnd_ff, rnd_in;
   logic                  final_ff, final_in;     // marker word owed, or compression ends message
   logic                  pad_ff, pad_in;         // padding of the last block underway
   logic [2:0]            idx_ff, idx_in;
   sha512_pkg::word_type  cv_ff [8];
   sha512_pkg::word_type  cv_in [8];
   sha512_pkg::word_type  vars [8];
   sha512_pkg::round_ctl_type ctl;
   logic                  wr_en;
   logic [3:0]            wr_addr;
   sha512_pkg::word_type  wr_data;
   logic                  req_fire;
   logic [3:0]            vb;
   logic [2:0]            last_idx;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == sha512_pkg::ST_IDLE);
   assign csr_tready = 1'b1;
   assign vb         = req_tdata[67:64];
   assign last_idx   = mode_ff ? 3'd5 : 3'd7;

   always_comb begin
      logic [3:0]  k;
      logic [63:0] mask;
      logic [127:0] len_base;
      state_in = state_ff;
      mode_in  = (csr_tvalid && csr_tready) ? csr_tdata[0] : mode_ff;
      open_in  = open_ff;
      fill_in  = fill_ff;
      len_in   = len_ff;
      rnd_in   = rnd_ff;
      final_in = final_ff;
      pad_in   = pad_ff;
      idx_in   = idx_ff;
      cv_in    = cv_ff;
      ctl      = '{load: 1'b0, step: 1'b0, rnd: rnd_ff};
      wr_en    = 1'b0;
      wr_addr  = fill_ff[3:0];
      wr_data  = '0;
      k        = (!req_tlast || vb > 4'd8) ? 4'd8 : vb;
      mask     = ~(64'hffffffffffffffff >> {k[3:0], 3'b000});
      len_base = open_ff ? len_ff : '0;
      unique case (state_ff)
         sha512_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (!open_ff) begin
                  for (int i = 0; i < 8; i++) begin
                     cv_in[i] = sha512_pkg::init_word(mode_ff, 3'(i));
                  end
                  fill_in = '0;
                  wr_addr = '0;
               end
               open_in = 1'b1;
               len_in  = len_base + {121'd0, k, 3'b000};
               wr_en   = 1'b1;
               if (k == 4'd8) begin
                  wr_data = req_tdata[63:0];
               end else begin
                  wr_data = (req_tdata[63:0] & mask) | (64'h8000000000000000 >> {k, 3'b000});
               end
               fill_in = (open_ff ? fill_ff : 5'd0) + 5'd1;
               final_in = 1'b0;
               pad_in   = req_tlast;
               if (req_tlast) begin
                  state_in = sha512_pkg::ST_PAD;
                  // full last word: the 0x80 marker goes in the next slot
                  if (k == 4'd8) final_in = 1'b1;
               end else if (fill_in == 5'd16) begin
                  state_in = sha512_pkg::ST_COMP;
                  ctl.load = 1'b1;
                  rnd_in   = '0;
                  fill_in  = '0;
               end
            end
         end
         sha512_pkg::ST_PAD: begin
            // final_ff set: a marker word is still owed
            wr_en = 1'b1;
            wr_data = final_ff ? 64'h8000000000000000 : '0;
            if (fill_ff == 5'd16) begin
               wr_en    = 1'b0;
               state_in = sha512_pkg::ST_COMP;
               ctl.load = 1'b1;
               rnd_in   = '0;
               fill_in  = '0;
            end else if (fill_ff == 5'd14 && !final_ff) begin
               wr_en    = 1'b0;
               state_in = sha512_pkg::ST_LENGTH;
            end else begin
               fill_in  = fill_ff + 5'd1;
               final_in = 1'b0;
            end
         end
         sha512_pkg::ST_LENGTH: begin
            // two-word length, high then low
            wr_en   = 1'b1;
            wr_addr = fill_ff[3:0];
            wr_data = (fill_ff == 5'd14) ? len_ff[127:64] : len_ff[63:0];
            fill_in = fill_ff + 5'd1;
            if (fill_ff == 5'd15) begin
               state_in = sha512_pkg::ST_COMP;
               ctl.load = 1'b1;
               rnd_in   = '0;
               fill_in  = '0;
               final_in = 1'b1;
               pad_in   = 1'b0;
            end
         end
         sha512_pkg::ST_COMP: begin
            ctl.step = 1'b1;
            rnd_in   = rnd_ff + 7'd1;
            if (rnd_ff == 7'(sha512_pkg::RoundCount - 1)) begin
               state_in = sha512_pkg::ST_FOLD;
            end
         end
         sha512_pkg::ST_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               cv_in[i] = cv_ff[i] + vars[i];
            end
            rnd_in = '0;
            idx_in = '0;
            // padding spilled into a second block: finish it there
            if (pad_ff) begin
               state_in = sha512_pkg::ST_PAD;
            end else if (final_ff) begin
               state_in = sha512_pkg::ST_EMIT;
            end else begin
               state_in = sha512_pkg::ST_IDLE;
            end
         end
         sha512_pkg::ST_EMIT: begin
            if (rsp_tready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == last_idx) begin
                  state_in = sha512_pkg::ST_IDLE;
                  open_in  = 1'b0;
                  final_in = 1'b0;
                  fill_in  = '0;
               end
            end
         end
         default: state_in = sha512_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha512_pkg::ST_IDLE;
         mode_ff  <= 1'b0;
         open_ff  <= 1'b0;
         fill_ff  <= '0;
         len_ff   <= '0;
         rnd_ff   <= '0;
         final_ff <= 1'b0;
         pad_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         open_ff  <= open_in;
         fill_ff  <= fill_in;
         len_ff   <= len_in;
         rnd_ff   <= rnd_in;
         final_ff <= final_in;
         pad_ff   <= pad_in;
         idx_ff   <= idx_in;
      end
      cv_ff <= cv_in;
   end

   sha512_round u_round (
      .clock   (clock),
      .ctl     (ctl),
      .cv      (cv_ff),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .vars    (vars)
   );

   assign rsp_tvalid = (state_ff == sha512_pkg::ST_EMIT);
   assign rsp_tdata  = cv_ff[idx_ff];
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = (idx_ff == last_idx);

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha512_pkg::ST_COMP |-> rnd_ff < 7'd80)
      else $error("round counter out of range");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != sha512_pkg::ST_IDLE |-> !req_tready)
      else $error("request accepted while busy");
   a_fold_after: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha512_pkg::ST_FOLD |-> $past(state_ff) == sha512_pkg::ST_COMP)
      else $error("fold without compression");
endmodule

// ----- dv/sha512_384_hash_engine_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-512 / SHA-384 hash engine testbench
// Streams random and directed messages through the engine in both modes and
// checks every digest word against a behavioral hash kept in this file.
// ----------------------------------------------------------------------------

// digest bookkeeping: hashes accepted words, queues expected digest words
class digest_scoreboard;
   typedef struct packed {
      logic [63:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_entry_type;

   digest_entry_type pending[$];
   logic [63:0]      chain[8];
   logic [63:0]      blk[16];
   int unsigned      fill;
   logic [127:0]     msg_bits;
   bit               msg_open;
   bit               mode;
   int unsigned      errors;
   int unsigned      digests;

   static const logic [63:0] rconst[80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

   static const logic [63:0] iv[2][8] = '{
      '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179},
      '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
        64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4}};

   function new();
      mode = 0;
      msg_open = 0;
      restart();
   endfunction

   function void restart();
      for (int i = 0; i < 8; i++) chain[i] = iv[mode][i];
      fill = 0;
      msg_bits = '0;
   endfunction

   function logic [63:0] rotr(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function void compress();
      logic [63:0] v[8];
      logic [63:0] w[80];
      logic [63:0] t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 80; i++)
         w[i] = w[i-16] + (rotr(w[i-15], 1) ^ rotr(w[i-15], 8) ^ (w[i-15] >> 7))
              + w[i-7] + (rotr(w[i-2], 19) ^ rotr(w[i-2], 61) ^ (w[i-2] >> 6));
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int r = 0; r < 80; r++) begin
         t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + rconst[r] + w[r];
         t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
   endfunction

   function void push_word(logic [63:0] w);
      blk[fill] = w;
      fill++;
      if (fill == 16) begin
         compress();
         fill = 0;
      end
   endfunction

   // one accepted request transaction
   function void note_word(logic [63:0] data, logic [3:0] nbytes, bit last);
      int unsigned k;
      int unsigned n;
      digest_entry_type e;
      if (!msg_open) begin
         restart();
         msg_open = 1;
      end
      k = (nbytes > 8 || !last) ? 8 : nbytes;
      msg_bits += 128'(k * 8);
      if (!last) begin
         push_word(data);
         return;
      end
      if (k == 8) begin
         push_word(data);
         blk[fill] = 64'h80 << 56;
      end else begin
         blk[fill] = ((k == 0) ? 64'd0 : (data & ~({64{1'b1}} >> (8 * k))))
                   | (64'h80 << (56 - 8 * k));
      end
      fill++;
      if (fill > 14) begin
         while (fill < 16) blk[fill++] = '0;
         compress();
         fill = 0;
      end
      while (fill < 14) blk[fill++] = '0;
      blk[14] = msg_bits[127:64];
      blk[15] = msg_bits[63:0];
      compress();
      n = mode ? 6 : 8;
      for (int i = 0; i < n; i++) begin
         e.word = chain[i];
         e.index = 3'(i);
         e.last = (i + 1 == n);
         pending.push_back(e);
      end
      msg_open = 0;
      digests++;
   endfunction

   // one accepted response transaction
   function void check_digest(logic [63:0] word, logic [2:0] index, logic last);
      digest_entry_type e;
      if (pending.size() == 0) begin
         $error("unexpected digest word %h", word);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (word !== e.word) begin
         $error("digest_word expected %h actual %h", e.word, word);
         errors++;
      end
      if (index !== e.index) begin
         $error("word_index expected %0d actual %0d", e.index, index);
         errors++;
      end
      if (last !== e.last) begin
         $error("last_digest expected %0d actual %0d", e.last, last);
         errors++;
      end
   endfunction
endclass

module sha512_384_hash_engine_tb;

   localparam int HoldCycles = 400;    // long receiver hold-off
   localparam int IdleLimit  = 5000;   // cycles without any transaction
   localparam int DrainWait  = 300;    // settle wait after last digest

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;    // [63:0] data_word, [67:64] valid_bytes
   logic        req_tlast;    // last_word
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;    // [63:0] digest_word
   logic [2:0]  rsp_tuser;    // [2:0] word_index
   logic        rsp_tlast;    // last_digest
   logic        csr_tvalid;
   logic        csr_tready;
   logic [7:0]  csr_tdata;    // [0] hash_mode

   digest_scoreboard digests_sb;
   int unsigned      words_sent;
   int unsigned      idle_cycles;
   bit               hold_rsp;
   bit               quiet;       // gaps off for the current burst pattern

   sha512_384_hash_engine DUT (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // response side: pattern stall, plus a long hold requested by the stimulus
   initial begin
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (HoldCycles) @(posedge clock);
            hold_rsp = 0;
         end
         rsp_tready <= quiet ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   // check on accepted response transactions; watchdog on idle cycles
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            digests_sb.check_digest(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)
             || (csr_tvalid && csr_tready))
            idle_cycles <= 0;
         else if (!hold_rsp)
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IdleLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // one request transaction; gaps come in bursts, valid stays up between
   // back-to-back transactions and is dropped by the gap or by a drain
   task automatic send_word(logic [63:0] data, logic [3:0] nbytes, bit last);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {4'b0, nbytes, data};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      digests_sb.note_word(data, nbytes, last);
      words_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (digests_sb.pending.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   // mode change only with the engine idle
   task automatic write_mode(bit mode);
      wait_drained();
      csr_tvalid <= 1;
      csr_tdata  <= {7'b0, mode};
      do @(posedge clock); while (!csr_tready);
      csr_tvalid <= 0;
      digests_sb.mode = mode;
   endtask

   task automatic random_message(int unsigned len);
      logic [63:0] d;
      for (int i = 0; i < len; i++) begin
         d = {$urandom, $urandom};
         if (i + 1 < len)
            send_word(d, 4'($urandom_range(0, 15)), 0);
         else
            send_word(d, 4'($urandom_range(0, 4) == 0 ? $urandom_range(9, 15)
                                                      : $urandom_range(0, 8)), 1);
      end
   endtask

   initial begin
      int unsigned len;
      digests_sb  = new();
      reset       = 1;
      req_tvalid  = 0;
      req_tdata   = '0;
      req_tlast   = 0;
      csr_tvalid  = 0;
      csr_tdata   = '0;
      hold_rsp    = 0;
      quiet       = 0;
      idle_cycles = 0;
      words_sent  = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty message, each tail size, block-edge lengths, extremes
      send_word(64'h0, 4'd0, 1);
      for (int k = 1; k <= 8; k++)
         send_word({64{1'b1}}, 4'(k), 1);
      send_word(64'h0123456789abcdef, 4'd15, 1);          // oversized count
      for (int i = 0; i < 14; i++)
         send_word(64'h0, 4'd3, i == 13);                  // tail leaves just room for the length
      write_mode(1);
      send_word(64'h6162630000000000, 4'd3, 1);
      send_word({64{1'b1}}, 4'd8, 1);
      write_mode(0);
      // sender pauses until all digests are back
      wait_drained();

      // random messages; mode flips between phases
      while (words_sent < 330) begin
         if ($urandom_range(0, 9) == 0) write_mode($urandom_range(0, 1));
         quiet = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 12) == 0) hold_rsp = 1;
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 34) : $urandom_range(1, 10);
         random_message(len);
      end
      write_mode(1);
      hold_rsp = 1;            // fill the engine against a stalled output
      random_message(3);
      random_message(2);
      random_message(1);
      quiet = 0;
      wait_drained();

      $display("Sent %0d message words, %0d digests in SHA-512 and SHA-384 modes.",
               words_sent, digests_sb.digests);
      if (digests_sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
